// ===== rtl/core/bmhp_pkg.sv =====
`default_nettype none
// ============================================================================
// Block map hash probe table package
// Shared widths, operation and status codes, controller/datapath bundles and
// the home-slot hash.
// ============================================================================
package bmhp_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int ID_BITS_DEF  = 16;

    localparam int MODE_W   = 2;
    localparam int ADDR_W   = 32;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;

    typedef enum logic [MODE_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT          = 3'd0,
        ST_MISS         = 3'd1,
        ST_INSERTED     = 3'd2,
        ST_INSERTED_CLR = 3'd3,
        ST_FULL_CLR     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_CHECK,
        S_CLEAR,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_item;
        logic    start_probe;
        logic    step_probe;
        logic    write_entry;
        logic    sweep_step;
        logic    wipe_count;
        logic    mark_cleared;
        logic    res_load;
        status_t res_status;
        logic    res_take_id;
        logic    out_load;
    } bmhp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic need_clear;
        logic cleared;
        logic slot_empty;
        logic key_match;
        logic probe_last;
        logic sweep_last;
        logic out_free;
    } bmhp_stat_t;

    // Xorshift over a 64-bit value; only the low word is kept.
    function automatic logic [ADDR_W-1:0] home_hash(input logic [ADDR_W-1:0] addr);
        logic [63:0] k;
        k = {32'd0, addr};
        k = k ^ (k << 21);
        k = k ^ (k >> 17);
        k = k ^ (k >> 35);
        k = k ^ (k >> 51);
        return k[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/block_map_hash_probe_table_unit.sv =====
`default_nettype none
// ============================================================================
// Block map hash probe table unit
// Open-addressed table with linear probing that maps a block start address
// to a stored block identifier; lookup, insert with auto-clear, and clear.
// ============================================================================
//
//   Channel | Handshake            | Payload
//   --------+----------------------+----------------------------------
//   req     | req_valid, req_stall | mode, start_address, entry_id
//   rsp     | rsp_valid, rsp_stall | status, found_id
//
// A lookup or insert runs from the hash state through the probe, which checks
// one slot per cycle through the slot memory's registered read port, to the
// finish state that raises rsp_valid; the next request is taken back in idle.
// A clear first sweeps the slot memory, invalidating one slot per cycle, and
// an insert that triggers the auto-clear runs the same sweep and then hashes
// again before it probes. After reset the same sweep runs with req_stall high.
// A result beat waits in the output register while rsp_stall is high; a new
// request is still taken in the meantime, but its result is held back until
// the waiting beat is taken.
//
module block_map_hash_probe_table_unit #(
    parameter int CAPACITY = bmhp_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = bmhp_pkg::ID_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [bmhp_pkg::MODE_W-1:0]   mode,
    input  wire logic [bmhp_pkg::ADDR_W-1:0]   start_address,
    input  wire logic [bmhp_pkg::ID_W-1:0]     entry_id,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [bmhp_pkg::STATUS_W-1:0]      status,
    output logic [bmhp_pkg::ID_W-1:0]          found_id
);
    import bmhp_pkg::*;

    bmhp_cmd_t  cmd;
    bmhp_stat_t stat;

    bmhp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bmhp_dpath #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode),
        .start_address (start_address),
        .entry_id      (entry_id),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .found_id      (found_id),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule
`default_nettype wire

// ===== rtl/core/bmhp_ctrl.sv =====
`default_nettype none
// ============================================================================
// Block map hash probe table controller
// Sequences hashing, probing, table sweeps and result hand-off.
// ============================================================================
module bmhp_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire bmhp_pkg::bmhp_stat_t stat,
    output bmhp_pkg::bmhp_cmd_t       cmd
);
    import bmhp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                case (stat.op)
                    OP_LOOKUP: state_next = S_CHECK;
                    OP_INSERT: state_next = stat.need_clear ? S_CLEAR : S_CHECK;
                    OP_CLEAR:  state_next = S_CLEAR;
                    default:   state_next = S_FINISH;
                endcase
            end
            S_CHECK:
            begin
                if (stat.slot_empty || stat.probe_last ||
                    (stat.op == OP_LOOKUP && stat.key_match))
                begin
                    state_next = S_FINISH;
                end
            end
            S_CLEAR:
            begin
                if (stat.sweep_last)
                begin
                    state_next = (stat.op == OP_INSERT) ? S_HASH : S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.res_status = ST_MISS;
        req_stall = (state_reg != S_IDLE);
        unique case (state_reg)
            S_INIT:
            begin
                cmd.sweep_step = 1'b1;
            end
            S_IDLE:
            begin
                cmd.load_item = req_valid;
            end
            S_HASH:
            begin
                case (stat.op)
                    OP_LOOKUP:
                    begin
                        cmd.start_probe = 1'b1;
                    end
                    OP_INSERT:
                    begin
                        if (stat.need_clear)
                        begin
                            cmd.wipe_count   = 1'b1;
                            cmd.mark_cleared = 1'b1;
                        end
                        else
                        begin
                            cmd.start_probe = 1'b1;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.wipe_count = 1'b1;
                    end
                    default:
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_MISS;
                    end
                endcase
            end
            S_CHECK:
            begin
                if (stat.slot_empty)
                begin
                    cmd.res_load = 1'b1;
                    if (stat.op == OP_INSERT)
                    begin
                        cmd.write_entry = 1'b1;
                        cmd.res_status  = stat.cleared ? ST_INSERTED_CLR : ST_INSERTED;
                    end
                    else
                    begin
                        cmd.res_status = ST_MISS;
                    end
                end
                else if (stat.op == OP_LOOKUP && stat.key_match)
                begin
                    cmd.res_load    = 1'b1;
                    cmd.res_status  = ST_HIT;
                    cmd.res_take_id = 1'b1;
                end
                else if (stat.probe_last)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = (stat.op == OP_INSERT) ? ST_FULL_CLR : ST_MISS;
                end
                else
                begin
                    cmd.step_probe = 1'b1;
                end
            end
            S_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last && stat.op != OP_INSERT)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_FULL_CLR;
                end
            end
            S_FINISH:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    ap_accept_to_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_HASH))
        else $error("accepted beat did not start hashing");

    ap_result_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over an untaken beat");

    ap_insert_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && stat.sweep_last && stat.op == OP_INSERT)
        |=> (state_reg == S_HASH && stat.cleared && !stat.need_clear))
        else $error("insert did not resume with an empty table after auto-clear");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/bmhp_dpath.sv =====
`default_nettype none
// ============================================================================
// Block map hash probe table datapath
// Slot memory, item and probe registers, entry count, sweep counter and the
// result output register.
// ============================================================================
module bmhp_dpath #(
    parameter int CAPACITY = bmhp_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = bmhp_pkg::ID_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [bmhp_pkg::MODE_W-1:0]   mode,
    input  wire logic [bmhp_pkg::ADDR_W-1:0]   start_address,
    input  wire logic [bmhp_pkg::ID_W-1:0]     entry_id,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [bmhp_pkg::STATUS_W-1:0]      status,
    output logic [bmhp_pkg::ID_W-1:0]          found_id,
    input  wire bmhp_pkg::bmhp_cmd_t           cmd,
    output bmhp_pkg::bmhp_stat_t               stat
);
    import bmhp_pkg::*;

    localparam int SLOT_BITS  = $clog2(CAPACITY);
    localparam int CNT_BITS   = SLOT_BITS + 1;
    localparam int STORE_BITS = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int ENTRY_W    = 1 + ADDR_W + STORE_BITS;
    localparam logic [CNT_BITS-1:0]   CNT_FULL  = CNT_BITS'(CAPACITY);
    localparam logic [CNT_BITS+2:0]   CLR_LIMIT = (CNT_BITS + 3)'(CAPACITY * 4);

    // Slot memory: valid bit, key and identifier per slot.
    logic [ENTRY_W-1:0] slot_mem [CAPACITY];

    op_t                   op_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [STORE_BITS-1:0] id_reg;
    logic [SLOT_BITS-1:0]  slot_reg;
    logic [SLOT_BITS-1:0]  slot_next;
    logic [SLOT_BITS-1:0]  probe_cnt_reg;
    logic [SLOT_BITS-1:0]  probe_cnt_next;
    logic [ENTRY_W-1:0]    rd_entry_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic [SLOT_BITS-1:0]  sweep_idx_reg;
    logic [SLOT_BITS-1:0]  sweep_idx_next;
    logic                  cleared_reg;
    logic                  cleared_next;
    status_t               res_status_reg;
    logic [ID_W-1:0]       res_id_reg;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [ID_W-1:0]       found_id_reg;

    logic [ADDR_W-1:0]     home_word;
    logic [SLOT_BITS-1:0]  home_slot;
    logic [SLOT_BITS-1:0]  slot_inc;
    logic [SLOT_BITS-1:0]  rd_addr;
    logic                  rd_valid;
    logic [ADDR_W-1:0]     rd_key;
    logic [STORE_BITS-1:0] rd_id;
    logic [ID_W-1:0]       rd_id_ext;
    logic [CNT_BITS+2:0]   count_x5;
    logic                  mem_we;
    logic [SLOT_BITS-1:0]  wr_addr;
    logic [ENTRY_W-1:0]    wr_entry;
    logic                  out_free;

    assign home_word = home_hash(addr_reg);
    assign home_slot = home_word[SLOT_BITS-1:0];
    assign slot_inc  = slot_reg + SLOT_BITS'(1);
    // While the current slot is checked, the next one is already read.
    assign rd_addr   = cmd.start_probe ? home_slot : slot_inc;

    assign rd_valid = rd_entry_reg[ENTRY_W-1];
    assign rd_key   = rd_entry_reg[ENTRY_W-2 -: ADDR_W];
    assign rd_id    = rd_entry_reg[STORE_BITS-1:0];

    always_comb
    begin
        rd_id_ext = '0;
        rd_id_ext[STORE_BITS-1:0] = rd_id;
    end

    assign count_x5 = {1'b0, count_reg, 2'b00} + {3'b000, count_reg};

    assign mem_we   = cmd.sweep_step || cmd.write_entry;
    assign wr_addr  = cmd.sweep_step ? sweep_idx_reg : slot_reg;
    assign wr_entry = cmd.sweep_step ? '0 : {1'b1, addr_reg, id_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= slot_mem[rd_addr];
    end

    always_comb
    begin
        slot_next      = slot_reg;
        probe_cnt_next = probe_cnt_reg;
        if (cmd.start_probe)
        begin
            slot_next      = home_slot;
            probe_cnt_next = '0;
        end
        else if (cmd.step_probe)
        begin
            slot_next      = slot_inc;
            probe_cnt_next = probe_cnt_reg + SLOT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= op_t'(mode);
            addr_reg <= start_address;
            id_reg   <= entry_id[STORE_BITS-1:0];
        end
        slot_reg      <= slot_next;
        probe_cnt_reg <= probe_cnt_next;
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_id_reg     <= cmd.res_take_id ? rd_id_ext : '0;
        end
        if (cmd.out_load)
        begin
            status_reg   <= res_status_reg;
            found_id_reg <= res_id_reg;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.wipe_count)
        begin
            count_next = '0;
        end
        else if (cmd.write_entry && count_reg != CNT_FULL)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
    end

    assign sweep_idx_next = cmd.sweep_step ? sweep_idx_reg + SLOT_BITS'(1) : sweep_idx_reg;
    assign cleared_next   = cmd.mark_cleared ? 1'b1 :
                            (cmd.load_item ? 1'b0 : cleared_reg);

    assign out_free       = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid_next = cmd.out_load ? 1'b1 : (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sweep_idx_reg <= '0;
            cleared_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sweep_idx_reg <= sweep_idx_next;
            cleared_reg   <= cleared_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign stat.op         = op_reg;
    assign stat.need_clear = (count_x5 > CLR_LIMIT);
    assign stat.cleared    = cleared_reg;
    assign stat.slot_empty = !rd_valid;
    assign stat.key_match  = (rd_key == addr_reg);
    assign stat.probe_last = (probe_cnt_reg == '1);
    assign stat.sweep_last = (sweep_idx_reg == '1);
    assign stat.out_free   = out_free;

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign found_id  = found_id_reg;

`ifndef SYNTHESIS
    ap_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count above capacity");

    ap_write_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_entry |-> (!rd_valid && !cmd.sweep_step))
        else $error("insert wrote over a live slot or during a sweep");

    ap_count_follows_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write_entry && count_reg != CNT_FULL)
        |=> (count_reg == $past(count_reg) + CNT_BITS'(1)))
        else $error("entry count missed an insert");
`endif

endmodule
`default_nettype wire
